@@ hw/rtl/ste_pkg.sv @@
// shared types and constants for the supervisor trap entry block
package ste_pkg;

    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 30;
    localparam int unsigned XlenW    = 32;
    localparam int unsigned CodeW    = 5;
    localparam int unsigned BaseW    = 30;
    localparam int unsigned IrqW     = 3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_VECTOR_BASE       = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_VECTOR_MODE       = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_INTERRUPT_ENABLES = 2'd2;

    // opcodes
    localparam logic OP_EXCEPTION = 1'b0;
    localparam logic OP_IRQ_CHECK = 1'b1;

    // privilege modes
    localparam logic MODE_USER = 1'b0;
    localparam logic MODE_SUPV = 1'b1;

    // vector modes
    localparam logic VEC_DIRECT   = 1'b0;
    localparam logic VEC_VECTORED = 1'b1;

    // interrupt source bits
    localparam int unsigned IRQ_SOFT  = 0;
    localparam int unsigned IRQ_TIMER = 1;
    localparam int unsigned IRQ_EXT   = 2;

    // interrupt cause codes
    localparam logic [CodeW-1:0] CODE_SOFT  = 5'd1;
    localparam logic [CodeW-1:0] CODE_TIMER = 5'd5;
    localparam logic [CodeW-1:0] CODE_EXT   = 5'd9;

    typedef struct packed {
        logic [BaseW-1:0] vector_base;
        logic             vector_mode;
        logic [IrqW-1:0]  interrupt_enables;
    } t_ste_cfg;

    typedef struct packed {
        logic             opcode;
        logic [CodeW-1:0] exc_code;
        logic [XlenW-1:0] fault_value;
        logic [XlenW-1:0] current_pc;
        logic             core_mode;
        logic             global_ie;
        logic             ll_sc_active;
        logic [IrqW-1:0]  pending;
    } t_ste_in;

    typedef struct packed {
        logic             trap_taken;
        logic [XlenW-1:0] new_pc;
        logic             cause_interrupt;
        logic [CodeW-1:0] cause_code;
        logic [XlenW-1:0] saved_pc;
        logic [XlenW-1:0] trap_value;
        logic             new_sie;
        logic             new_spie;
        logic             new_spp;
        logic             new_mode;
    } t_ste_out;

endpackage

@@ hw/rtl/supervisor_trap_entry.sv @@
// supervisor trap entry: input register, trap evaluation, result register
//
// usage:
//   input channel i_valid / o_ready / i_data carries one trap request per beat:
//   either an exception (code, fault value, pc) or an interrupt check.
//   output channel o_valid / i_ready / o_data returns exactly one result per
//   request: trap taken flag, handler pc, cause, saved pc, trap value and the
//   updated sie / spie / spp / mode bits.
//   configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 vector base, 1 vector mode, 2 interrupt enables); write only while no
//   request is in flight.
// path: an accepted request passes the input register, then the result
//   register, before it is offered on the output.
// throughput: one request per cycle while i_ready is high; the evaluation
//   between the two registers is a short priority select and a 30-bit add.
// reset: i_rst_n is synchronous, active low; it empties both stages and
//   clears the configuration registers to zero.
// stall: when i_ready is low the result register holds its beat, the input
//   register takes one more beat only if it is empty, then o_ready drops.
module supervisor_trap_entry (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ste_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [ste_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  ste_pkg::t_ste_in             i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output ste_pkg::t_ste_out            o_data
);
    import ste_pkg::*;

    t_ste_cfg cfg;
    t_ste_in  r_item;
    logic     r_item_valid;
    t_ste_out n_result;
    t_ste_out r_result;
    logic     r_result_valid;
    logic     result_ready;
    logic     item_ready;

    ste_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ste_eval u_eval (
        .i_cfg    (cfg),
        .i_item   (r_item),
        .o_result (n_result)
    );

    assign result_ready = !r_result_valid || i_ready;
    assign item_ready   = !r_item_valid || result_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (item_ready) begin
            r_item_valid <= i_valid;
        end
        if (item_ready && i_valid) begin
            r_item <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else if (result_ready) begin
            r_result_valid <= r_item_valid;
        end
        if (result_ready && r_item_valid) begin
            r_result <= n_result;
        end
    end

    assign o_ready = item_ready;
    assign o_valid = r_result_valid;
    assign o_data  = r_result;

endmodule

@@ hw/rtl/ste_cfg.sv @@
// configuration registers: vector base, vector mode and interrupt enables
module ste_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ste_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [ste_pkg::CfgDataW-1:0]    i_cfg_data,
    output ste_pkg::t_ste_cfg               o_cfg
);
    import ste_pkg::*;

    t_ste_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VECTOR_BASE:       r_cfg.vector_base       <= i_cfg_data[BaseW-1:0];
                CFG_VECTOR_MODE:       r_cfg.vector_mode       <= i_cfg_data[0];
                CFG_INTERRUPT_ENABLES: r_cfg.interrupt_enables <= i_cfg_data[IrqW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/ste_eval.sv @@
// trap decision, cause selection, handler address and status update
module ste_eval (
    input  ste_pkg::t_ste_cfg i_cfg,
    input  ste_pkg::t_ste_in  i_item,
    output ste_pkg::t_ste_out o_result
);
    import ste_pkg::*;

    logic [IrqW-1:0]  active;
    logic             irq_allowed;
    logic             irq_taken;
    logic [CodeW-1:0] irq_code;
    logic             taken;
    logic [XlenW-1:0] base_addr;
    logic [XlenW-1:0] vec_addr;
    logic [XlenW-1:0] handler_pc;

    assign active = i_item.pending & i_cfg.interrupt_enables;

    // user mode takes interrupts regardless of sie; an lr/sc pair blocks them
    assign irq_allowed = !i_item.ll_sc_active
                         && !(i_item.core_mode == MODE_SUPV && !i_item.global_ie);

    // priority: external, software, timer
    always_comb begin
        irq_taken = 1'b1;
        if (active[IRQ_EXT]) begin
            irq_code = CODE_EXT;
        end else if (active[IRQ_SOFT]) begin
            irq_code = CODE_SOFT;
        end else if (active[IRQ_TIMER]) begin
            irq_code = CODE_TIMER;
        end else begin
            irq_code  = '0;
            irq_taken = 1'b0;
        end
    end

    assign base_addr = {i_cfg.vector_base, 2'b00};
    assign vec_addr  = {i_cfg.vector_base + BaseW'(irq_code), 2'b00};

    always_comb begin
        o_result = '0;
        if (i_item.opcode == OP_EXCEPTION) begin
            taken                    = 1'b1;
            handler_pc               = base_addr;
            o_result.cause_interrupt = 1'b0;
            o_result.cause_code      = i_item.exc_code;
            o_result.trap_value      = i_item.fault_value;
        end else begin
            taken                    = irq_allowed && irq_taken;
            handler_pc               = (i_cfg.vector_mode == VEC_VECTORED) ? vec_addr
                                                                           : base_addr;
            o_result.cause_interrupt = taken;
            o_result.cause_code      = taken ? irq_code : '0;
            o_result.trap_value      = '0;
        end

        o_result.trap_taken = taken;
        if (taken) begin
            o_result.new_pc   = handler_pc;
            o_result.saved_pc = i_item.current_pc;
            o_result.new_sie  = 1'b0;
            o_result.new_spie = i_item.global_ie;
            o_result.new_spp  = i_item.core_mode;
            o_result.new_mode = MODE_SUPV;
        end else begin
            o_result                = '0;
            o_result.new_pc         = i_item.current_pc;
            o_result.new_sie        = i_item.global_ie;
            o_result.new_mode       = i_item.core_mode;
        end
    end

endmodule
